// ----- rtl/core/afb_pkg.sv -----
// Shared constants, types and width helpers for the afterimage frame blend.
package afb_pkg;

    // Default geometry of the plane store.
    localparam int MAX_FRAME_PIXELS_DEF = 76800;
    localparam int PLANE_COUNT_DEF      = 32;
    localparam int PLANE_STRIDE_DEF     = 8;

    // Number of planes summed for every pixel.
    localparam int N_TERMS = 4;

    // Pixel and quarter-intensity pixel widths.
    localparam int PIX_W  = 24;
    localparam int QCH_W  = 6;
    localparam int QPIX_W = 3 * QCH_W;

    // Frame length register.
    localparam int                ACTIVE_W     = 17;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 17'd76800;

    typedef logic [PIX_W-1:0]  t_pixel;
    typedef logic [QPIX_W-1:0] t_qpix;

    // Address width of one plane; never below one bit.
    function automatic int pos_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ----- rtl/core/afb_if.sv -----
// Valid/ready channel interfaces for input and output pixels.
interface afb_in_if;
    import afb_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface afb_out_if;
    import afb_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

// ----- rtl/core/afb_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module afb_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [afb_pkg::pos_width(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [afb_pkg::pos_width(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when both ports hit the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/afb_ctrl.sv -----
// Frame position and plane counters, frame length register and store clearing pass.
module afb_ctrl #(
    parameter int MAX_FRAME_PIXELS = afb_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int PLANE_COUNT      = afb_pkg::PLANE_COUNT_DEF,
    parameter int PLANE_STRIDE     = afb_pkg::PLANE_STRIDE_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_cfg_we,
    input  logic [afb_pkg::ACTIVE_W-1:0]                    i_cfg_wdata,
    input  logic                                            i_accept,
    output logic                                            o_clearing,
    output logic [afb_pkg::pos_width(MAX_FRAME_PIXELS)-1:0] o_clr_addr,
    output logic [afb_pkg::pos_width(MAX_FRAME_PIXELS)-1:0] o_pos,
    output logic [$clog2(PLANE_COUNT)-1:0]                  o_plane,
    output logic [afb_pkg::N_TERMS-1:0][$clog2(PLANE_COUNT)-1:0] o_terms
);
    import afb_pkg::*;

    localparam int PosW   = pos_width(MAX_FRAME_PIXELS);
    localparam int PlaneW = $clog2(PLANE_COUNT);
    localparam int CmpW   = (ACTIVE_W > PosW + 1) ? ACTIVE_W : PosW + 1;

    logic [ACTIVE_W-1:0] r_active_pixels;
    logic [PosW-1:0]     r_pos;
    logic [PosW-1:0]     n_pos;
    logic [PlaneW-1:0]   r_plane;
    logic [PlaneW-1:0]   n_plane;
    logic [PlaneW-1:0]   r_terms      [N_TERMS];
    logic [PlaneW-1:0]   n_terms      [N_TERMS];
    logic [PlaneW-1:0]   w_term_init  [N_TERMS];
    logic                r_clearing;
    logic [PosW-1:0]     r_clr_addr;

    logic [CmpW-1:0] w_act;
    logic [CmpW-1:0] w_len;
    logic [CmpW-1:0] w_next_pos;
    logic            w_wrap;
    logic            w_plane_last;
    logic            w_base_wrap;

    // Plane offsets right after the base plane returns to zero.
    for (genvar k = 0; k < N_TERMS; k++) begin : g_init
        localparam int TermInit = (k * PLANE_STRIDE) % PLANE_COUNT;
        assign w_term_init[k] = PlaneW'(TermInit);
    end

    // Effective frame length: zero acts as one, and the store depth caps it.
    always_comb begin
        w_act = CmpW'(r_active_pixels);
        if (w_act == '0) begin
            w_len = CmpW'(1);
        end else if (w_act > CmpW'(MAX_FRAME_PIXELS)) begin
            w_len = CmpW'(MAX_FRAME_PIXELS);
        end else begin
            w_len = w_act;
        end
        w_next_pos = CmpW'(r_pos) + CmpW'(1);
        w_wrap     = (w_next_pos >= w_len);
    end

    // Next position, plane and summed plane indexes.
    always_comb begin
        w_plane_last = (r_plane == PlaneW'(PLANE_COUNT - 1));
        // The first term is the current plane modulo the stride.
        w_base_wrap  = (32'(r_terms[0]) == 32'(PLANE_STRIDE - 1));
        n_pos        = w_wrap ? '0 : w_next_pos[PosW-1:0];
        n_plane      = w_plane_last ? '0 : r_plane + 1'b1;
        for (int k = 0; k < N_TERMS; k++) begin
            if (w_plane_last || w_base_wrap) begin
                n_terms[k] = w_term_init[k];
            end else if (r_terms[k] == PlaneW'(PLANE_COUNT - 1)) begin
                n_terms[k] = '0;
            end else begin
                n_terms[k] = r_terms[k] + 1'b1;
            end
        end
    end

    // The position advances with every accepted item; plane and terms only when the frame wraps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_plane <= '0;
            for (int k = 0; k < N_TERMS; k++) begin
                r_terms[k] <= w_term_init[k];
            end
        end else if (i_accept) begin
            r_pos <= n_pos;
            if (w_wrap) begin
                r_plane <= n_plane;
                for (int k = 0; k < N_TERMS; k++) begin
                    r_terms[k] <= n_terms[k];
                end
            end
        end
    end

    // Frame length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_pixels <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active_pixels <= i_cfg_wdata;
        end
    end

    // Clearing pass: one address of every plane per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == PosW'(MAX_FRAME_PIXELS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_clearing = r_clearing;
    assign o_clr_addr = r_clr_addr;
    assign o_pos      = r_pos;
    assign o_plane    = r_plane;
    always_comb begin
        for (int k = 0; k < N_TERMS; k++) begin
            o_terms[k] = r_terms[k];
        end
    end

    // No item may enter while the store is being cleared.
    a_no_accept_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_clearing |-> !i_accept
    ) else $error("item accepted during clearing pass");

    // The plane only changes at the start of a frame.
    a_plane_at_frame_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_plane != $past(r_plane)) |-> (r_pos == '0)
    ) else $error("plane advanced mid-frame");

    // The base plane never exceeds the current plane.
    a_base_below_plane: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_terms[0] <= r_plane
    ) else $error("base plane index out of step with current plane");
endmodule

// ----- rtl/core/afb_blend.sv -----
// Blend pipeline: term selection with write forwarding, channel sums and output register.
module afb_blend #(
    parameter int MAX_FRAME_PIXELS = afb_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int PLANE_COUNT      = afb_pkg::PLANE_COUNT_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_accept,
    input  afb_pkg::t_pixel                                 i_pixel,
    input  logic [afb_pkg::pos_width(MAX_FRAME_PIXELS)-1:0] i_pos,
    input  logic [$clog2(PLANE_COUNT)-1:0]                  i_plane,
    input  logic [afb_pkg::N_TERMS-1:0][$clog2(PLANE_COUNT)-1:0] i_terms,
    input  afb_pkg::t_qpix                                  i_rd_data [PLANE_COUNT],
    input  logic                                            i_out_ready,
    output logic                                            o_en,
    output logic                                            o_wr_en,
    output logic [afb_pkg::pos_width(MAX_FRAME_PIXELS)-1:0] o_wr_pos,
    output logic [$clog2(PLANE_COUNT)-1:0]                  o_wr_plane,
    output afb_pkg::t_qpix                                  o_wr_data,
    output logic                                            o_out_valid,
    output afb_pkg::t_pixel                                 o_out_pixel
);
    import afb_pkg::*;

    localparam int PosW   = pos_width(MAX_FRAME_PIXELS);
    localparam int PlaneW = $clog2(PLANE_COUNT);

    // Stage 1: item fields, read data arrives from the planes.
    logic                                r_s1_valid;
    t_qpix                               r_s1_qpix;
    logic [PosW-1:0]                     r_s1_pos;
    logic [PlaneW-1:0]                   r_s1_plane;
    logic [N_TERMS-1:0][PlaneW-1:0]      r_s1_terms;

    // Stage 2: selected terms, sum and write-back.
    logic                                r_s2_valid;
    logic [PosW-1:0]                     r_s2_pos;
    logic [PlaneW-1:0]                   r_s2_plane;
    t_qpix                               r_s2_terms [N_TERMS];

    // Last write, for the item that read just before it landed.
    logic                                r_lw_valid;
    logic [PosW-1:0]                     r_lw_pos;
    logic [PlaneW-1:0]                   r_lw_plane;
    t_qpix                               r_lw_data;

    // Output register.
    logic                                r_out_valid;
    t_pixel                              r_out_pixel;

    t_qpix                               w_s1_terms [N_TERMS];
    t_pixel                              w_s2_sum;
    t_qpix                               w_s2_quarter;
    logic [PlaneW-1:0]                   w_p;
    logic                                w_hit_s2;
    logic                                w_hit_lw;

    // The pipeline moves unless a finished item is blocked behind a full output.
    assign o_en = !r_s2_valid || !r_out_valid || i_out_ready;

    // Stage 1 term selection: own input, then newer writes, then stored value.
    always_comb begin
        w_p      = '0;
        w_hit_s2 = 1'b0;
        w_hit_lw = 1'b0;
        for (int k = 0; k < N_TERMS; k++) begin
            w_p      = r_s1_terms[k];
            w_hit_s2 = r_s2_valid && (r_s2_pos == r_s1_pos) && (r_s2_plane == w_p);
            w_hit_lw = r_lw_valid && (r_lw_pos == r_s1_pos) && (r_lw_plane == w_p);
            if (w_p == r_s1_plane) begin
                w_s1_terms[k] = r_s1_qpix;
            end else if (w_hit_s2) begin
                w_s1_terms[k] = w_s2_quarter;
            end else if (w_hit_lw) begin
                w_s1_terms[k] = r_lw_data;
            end else begin
                w_s1_terms[k] = i_rd_data[w_p];
            end
        end
    end

    // Stage 2 channel sums; four six-bit terms never carry out of a byte.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_s2_sum[c*8 +: 8] = 8'(r_s2_terms[0][c*QCH_W +: QCH_W])
                               + 8'(r_s2_terms[1][c*QCH_W +: QCH_W])
                               + 8'(r_s2_terms[2][c*QCH_W +: QCH_W])
                               + 8'(r_s2_terms[3][c*QCH_W +: QCH_W]);
            w_s2_quarter[c*QCH_W +: QCH_W] = w_s2_sum[c*8 + 2 +: QCH_W];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_lw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_en) begin
                r_s1_valid <= i_accept;
                r_s2_valid <= r_s1_valid;
                r_lw_valid <= r_s2_valid;
            end
            if (o_en && r_s2_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_s1_qpix  <= {i_pixel[23:18], i_pixel[15:10], i_pixel[7:2]};
            r_s1_pos   <= i_pos;
            r_s1_plane <= i_plane;
            r_s1_terms <= i_terms;
            r_s2_pos   <= r_s1_pos;
            r_s2_plane <= r_s1_plane;
            for (int k = 0; k < N_TERMS; k++) begin
                r_s2_terms[k] <= w_s1_terms[k];
            end
            r_lw_pos   <= r_s2_pos;
            r_lw_plane <= r_s2_plane;
            r_lw_data  <= w_s2_quarter;
        end
        if (o_en && r_s2_valid) begin
            r_out_pixel <= w_s2_sum;
        end
    end

    // Write-back of the quarter-intensity result into the current plane.
    assign o_wr_en     = o_en && r_s2_valid;
    assign o_wr_pos    = r_s2_pos;
    assign o_wr_plane  = r_s2_plane;
    assign o_wr_data   = w_s2_quarter;
    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;

    // An accepted item is in stage 1 on the next cycle.
    a_accept_enters_s1: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) i_accept |=> r_s1_valid
    ) else $error("accepted item did not enter the pipeline");

    // A finished item always lands in the output register.
    a_s2_to_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) (o_en && r_s2_valid) |=> r_out_valid
    ) else $error("finished item lost before the output register");

    // A held output is never overwritten by the pipeline.
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(o_en && r_s2_valid)
    ) else $error("waiting output overwritten");
endmodule

// ----- rtl/core/afterimage_frame_blend.sv -----
// Top level of the afterimage frame blend: channels, plane store and pipeline.
//
// Pixels enter on i_pix (valid/ready) in raster order and leave on o_pix, one
// result item for every accepted item, in the same order. The frame length is
// written through i_cfg_we/i_cfg_wdata while the block is idle; zero acts as
// one pixel and values above the store depth act as the store depth.
// Throughput is one item per cycle outside the clearing pass and while the
// receiver keeps up: each plane memory sees one read and one write per cycle,
// and every item reads all planes and writes one. An item passes three register
// stages (stage 1, stage 2, output register) before it is offered on o_pix.
// Writes still in flight are forwarded to later items at the same pixel
// position, so short frames run at full rate too. After reset the block clears
// every plane, one pixel address of all planes per cycle, over all MAX_FRAME_PIXELS
// addresses (76800 by default); i_pix is not ready during that pass,
// configuration writes are taken. When the receiver stalls, the result waits
// in the output register and the pipeline keeps accepting items until its last
// stage is also full; then ready drops and nothing is lost or repeated.
module afterimage_frame_blend #(
    parameter int MAX_FRAME_PIXELS = afb_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int PLANE_COUNT      = afb_pkg::PLANE_COUNT_DEF,
    parameter int PLANE_STRIDE     = afb_pkg::PLANE_STRIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [afb_pkg::ACTIVE_W-1:0] i_cfg_wdata,
    afb_in_if.sink                       i_pix,
    afb_out_if.source                    o_pix
);
    import afb_pkg::*;

    localparam int PosW   = pos_width(MAX_FRAME_PIXELS);
    localparam int PlaneW = $clog2(PLANE_COUNT);

    logic                           w_clearing;
    logic [PosW-1:0]                w_clr_addr;
    logic [PosW-1:0]                w_pos;
    logic [PlaneW-1:0]              w_plane;
    logic [N_TERMS-1:0][PlaneW-1:0] w_terms;
    logic                           w_en;
    logic                           w_accept;
    logic                           w_wr_en;
    logic [PosW-1:0]                w_wr_pos;
    logic [PlaneW-1:0]              w_wr_plane;
    t_qpix                          w_wr_data;
    t_qpix                          w_rd_data [PLANE_COUNT];
    logic                           w_out_valid;
    t_pixel                         w_out_pixel;

    // Input handshake.
    assign i_pix.ready = w_en && !w_clearing;
    assign w_accept    = i_pix.valid && i_pix.ready;

    // Counters, frame length and clearing pass.
    afb_ctrl #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
        .PLANE_COUNT      (PLANE_COUNT),
        .PLANE_STRIDE     (PLANE_STRIDE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .o_clearing  (w_clearing),
        .o_clr_addr  (w_clr_addr),
        .o_pos       (w_pos),
        .o_plane     (w_plane),
        .o_terms     (w_terms)
    );

    // One memory per plane, all read at the current pixel position.
    for (genvar j = 0; j < PLANE_COUNT; j++) begin : g_plane
        logic            w_we;
        logic [PosW-1:0] w_waddr;
        t_qpix           w_wdata;

        assign w_we    = w_clearing || (w_wr_en && (w_wr_plane == PlaneW'(j)));
        assign w_waddr = w_clearing ? w_clr_addr : w_wr_pos;
        assign w_wdata = w_clearing ? '0 : w_wr_data;

        afb_ram #(
            .WIDTH (QPIX_W),
            .DEPTH (MAX_FRAME_PIXELS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_re    (w_en),
            .i_raddr (w_pos),
            .o_rdata (w_rd_data[j])
        );
    end

    // Blend pipeline.
    afb_blend #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
        .PLANE_COUNT      (PLANE_COUNT)
    ) u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_pixel     (i_pix.pixel_in),
        .i_pos       (w_pos),
        .i_plane     (w_plane),
        .i_terms     (w_terms),
        .i_rd_data   (w_rd_data),
        .i_out_ready (o_pix.ready),
        .o_en        (w_en),
        .o_wr_en     (w_wr_en),
        .o_wr_pos    (w_wr_pos),
        .o_wr_plane  (w_wr_plane),
        .o_wr_data   (w_wr_data),
        .o_out_valid (w_out_valid),
        .o_out_pixel (w_out_pixel)
    );

    // Output channel.
    assign o_pix.valid     = w_out_valid;
    assign o_pix.pixel_out = w_out_pixel;
endmodule
